[src/pmct_pkg.sv]
package pmct_pkg;

   // Field widths.
   localparam int BYTE_W = 8;
   localparam int XW     = 10;
   localparam int YW     = 9;
   localparam int ADDR_W = 16;

   // Frame geometry: words in one display line.
   localparam int LINE_WORDS   = 80;
   localparam int LINE_WORDS_W = $clog2(LINE_WORDS + 1);

   // Working width of the signed position sums.
   localparam int SUM_W = 12;

   // Reset values.
   localparam logic [XW-1:0] X_LIMIT_RESET = 10'd639;
   localparam logic [YW-1:0] Y_LIMIT_RESET = 9'd479;
   localparam logic [XW-1:0] POS_X_RESET   = 10'd320;
   localparam logic [YW-1:0] POS_Y_RESET   = 9'd240;

   // Status byte bit positions.
   localparam int STATUS_LEFT_BIT   = 0;
   localparam int STATUS_X_SIGN_BIT = 4;
   localparam int STATUS_Y_SIGN_BIT = 5;

   // Packet queue between the framer and the cursor unit.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ACK    = 2'd1,
      PHASE_STREAM = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SLOT_STATUS = 2'd0,
      SLOT_DX     = 2'd1,
      SLOT_DY     = 2'd2
   } slot_type;

   typedef struct packed {
      logic [BYTE_W-1:0] status;
      logic [BYTE_W-1:0] dx;
      logic [BYTE_W-1:0] dy;
   } packet_type;

   typedef struct packed {
      logic [XW-1:0] x_limit;
      logic [YW-1:0] y_limit;
   } limits_type;

endpackage

[src/ps2_mouse_cursor_tracker.sv]
// Each packet passes the packet queue, the position stage and the result register in that order.
// One request per cycle while the queue has room; every third byte in streaming gives one result.
// The two-entry packet queue and the result register let requests continue while a result waits.
// Reset is synchronous and active high: limits return to 639 and 479, the cursor to 320, 240.
// After reset the first byte is dropped and the second is taken as the acknowledge.
module ps2_mouse_cursor_tracker
   import pmct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [XW-1:0]     rsp_cursor_x,
   output logic [YW-1:0]     rsp_cursor_y,
   output logic              rsp_left_button,
   output logic [ADDR_W-1:0] rsp_word_address,
   output logic              rsp_byte_select,
   output logic [2:0]        rsp_bit_index,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // Register select: address bit 2 picks the Y limit.
   localparam logic REG_X_LIMIT = 1'b0;
   localparam logic REG_Y_LIMIT = 1'b1;

   logic [XW-1:0] x_limit_ff;
   logic [YW-1:0] y_limit_ff;
   logic          csr_write;
   limits_type    limits;
   logic          queue_full, queue_empty, push, pop;
   packet_type    push_packet, pop_packet;

   // Limit registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_X_LIMIT) begin
            x_limit_ff <= pwdata[XW-1:0];
         end
         if (paddr[2] == REG_Y_LIMIT) begin
            y_limit_ff <= pwdata[YW-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_Y_LIMIT) ? {{(32 - YW){1'b0}}, y_limit_ff}
                                             : {{(32 - XW){1'b0}}, x_limit_ff};
   assign limits = '{x_limit: x_limit_ff, y_limit: y_limit_ff};

   // Byte framer.
   pmct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_packet (push_packet)
   );

   // Packet queue.
   pmct_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_packet (push_packet),
      .full        (queue_full),
      .pop         (pop),
      .empty       (queue_empty),
      .pop_packet  (pop_packet)
   );

   // Cursor update and address generation.
   pmct_back u_back (
      .clock            (clock),
      .reset            (reset),
      .limits           (limits),
      .queue_empty      (queue_empty),
      .pop_packet       (pop_packet),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_word_address (rsp_word_address),
      .rsp_byte_select  (rsp_byte_select),
      .rsp_bit_index    (rsp_bit_index)
   );

endmodule

[src/pmct_front.sv]
module pmct_front
   import pmct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              queue_full,
   output logic              push,
   output packet_type        push_packet
);

   phase_type         phase_ff, phase_in;
   slot_type          slot_ff, slot_in;
   logic [BYTE_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] dx_ff, dx_in;
   logic              accept;

   // A request is refused only while the packet queue is full.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Link phase and packet framing.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         slot_ff   <= SLOT_STATUS;
         status_ff <= '0;
         dx_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         status_ff <= status_in;
         dx_ff     <= dx_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      dx_in       = dx_ff;
      push        = 1'b0;
      push_packet = '{status: status_ff, dx: dx_ff, dy: req_rx_byte};
      if (accept) begin
         case (phase_ff)
            PHASE_ACK: begin
               // The acknowledge byte is dropped and streaming begins.
               phase_in = PHASE_STREAM;
               slot_in  = SLOT_STATUS;
            end
            PHASE_STREAM: begin
               case (slot_ff)
                  SLOT_STATUS: begin
                     status_in = req_rx_byte;
                     slot_in   = SLOT_DX;
                  end
                  SLOT_DX: begin
                     dx_in   = req_rx_byte;
                     slot_in = SLOT_DY;
                  end
                  SLOT_DY: begin
                     slot_in = SLOT_STATUS;
                     push    = 1'b1;
                  end
                  default: begin
                     slot_in = SLOT_STATUS;
                  end
               endcase
            end
            default: begin
               // Idle, or the unused phase code: drop the byte.
               phase_in = PHASE_ACK;
            end
         endcase
      end
   end

endmodule

[src/pmct_queue.sv]
module pmct_queue
   import pmct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  packet_type push_packet,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output packet_type pop_packet
);

   packet_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign pop_packet = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Packet storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_packet;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone write");
`endif

endmodule

[src/pmct_back.sv]
module pmct_back
   import pmct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  limits_type        limits,
   input  logic              queue_empty,
   input  packet_type        pop_packet,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [XW-1:0]     rsp_cursor_x,
   output logic [YW-1:0]     rsp_cursor_y,
   output logic              rsp_left_button,
   output logic [ADDR_W-1:0] rsp_word_address,
   output logic              rsp_byte_select,
   output logic [2:0]        rsp_bit_index
);

   logic [XW-1:0]     pos_x_ff, pos_x_in;
   logic [YW-1:0]     pos_y_ff, pos_y_in;
   logic              a_valid_ff, a_valid_in;
   logic              a_left_ff;
   logic              b_valid_ff, b_valid_in;
   logic              a_ready, b_ready;
   logic [BYTE_W:0]   dx9, dy9;
   logic [SUM_W-1:0]  sum_x, sum_y;
   logic [YW+LINE_WORDS_W-1:0] row_offset;
   logic [ADDR_W-1:0] address;

   // Handshake between the position stage and the result register.
   assign b_ready    = !b_valid_ff || !rsp_stall;
   assign a_ready    = !a_valid_ff || b_ready;
   assign pop        = !queue_empty && a_ready;
   assign a_valid_in = pop || (a_valid_ff && !b_ready);
   assign b_valid_in = (a_valid_ff && b_ready) || (b_valid_ff && rsp_stall);

   // Sign-extended deltas; X is added and Y subtracted.
   assign dx9   = {pop_packet.status[STATUS_X_SIGN_BIT], pop_packet.dx};
   assign dy9   = {pop_packet.status[STATUS_Y_SIGN_BIT], pop_packet.dy};
   assign sum_x = {{(SUM_W - XW){1'b0}}, pos_x_ff}
                + {{(SUM_W - BYTE_W - 1){dx9[BYTE_W]}}, dx9};
   assign sum_y = {{(SUM_W - YW){1'b0}}, pos_y_ff}
                - {{(SUM_W - BYTE_W - 1){dy9[BYTE_W]}}, dy9};

   // Clamp both axes to zero and the programmed limit.
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (pop) begin
         if (sum_x[SUM_W-1]) begin
            pos_x_in = '0;
         end else if (sum_x[SUM_W-2:0] > (SUM_W - 1)'(limits.x_limit)) begin
            pos_x_in = limits.x_limit;
         end else begin
            pos_x_in = sum_x[XW-1:0];
         end
         if (sum_y[SUM_W-1]) begin
            pos_y_in = '0;
         end else if (sum_y[SUM_W-2:0] > (SUM_W - 1)'(limits.y_limit)) begin
            pos_y_in = limits.y_limit;
         end else begin
            pos_y_in = sum_y[YW-1:0];
         end
      end
   end

   // Frame address of the cursor, modulo the address width.
   assign row_offset = pos_y_ff * LINE_WORDS_W'(LINE_WORDS);
   assign address    = ADDR_W'(row_offset) + ADDR_W'({pos_x_ff[XW-1:4], 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= POS_X_RESET;
         pos_y_ff   <= POS_Y_RESET;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Payload of the position stage and the result register.
   always_ff @(posedge clock) begin
      if (pop) begin
         a_left_ff <= pop_packet.status[STATUS_LEFT_BIT];
      end
      if (a_valid_ff && b_ready) begin
         rsp_cursor_x     <= pos_x_ff;
         rsp_cursor_y     <= pos_y_ff;
         rsp_left_button  <= a_left_ff;
         rsp_word_address <= address;
         rsp_byte_select  <= pos_x_ff[3];
         rsp_bit_index    <= ~pos_x_ff[2:0];
      end
   end

   assign rsp_valid = b_valid_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) pop |=> a_valid_ff)
      else $error("popped packet did not reach the position stage");
   assert property (@(posedge clock) disable iff (reset)
                    (a_valid_ff && !b_ready) |=> ($stable(pos_x_ff) && $stable(pos_y_ff)))
      else $error("cursor moved while its result was held back");
`endif

endmodule

[sim/tb_ps2_mouse_cursor_tracker.sv]
module tb_ps2_mouse_cursor_tracker;
   import pmct_pkg::*;

   // Register indexes of the configuration port.
   localparam int REG_X_LIMIT = 0;
   localparam int REG_Y_LIMIT = 1;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   // One cursor update as it leaves the block.
   typedef struct packed {
      logic [XW-1:0]     cursor_x;
      logic [YW-1:0]     cursor_y;
      logic              left_button;
      logic [ADDR_W-1:0] word_address;
      logic              byte_select;
      logic [2:0]        bit_index;
   } cursor_type;

   // Tracks the mouse link and cursor, and holds the updates still to come.
   class cursor_scoreboard;
      logic [XW-1:0] x_limit;
      logic [YW-1:0] y_limit;
      phase_type     phase;
      slot_type      slot;
      logic [7:0]    status_byte;
      logic [7:0]    dx_byte;
      logic [XW-1:0] pos_x;
      logic [YW-1:0] pos_y;
      cursor_type    due_cursors[$];
      int            failures;
      int            updates_checked;
      int            edge_hits;

      function new();
         x_limit = X_LIMIT_RESET;
         y_limit = Y_LIMIT_RESET;
         phase = PHASE_IDLE;
         slot = SLOT_STATUS;
         status_byte = '0;
         dx_byte = '0;
         pos_x = POS_X_RESET;
         pos_y = POS_Y_RESET;
         failures = 0;
         updates_checked = 0;
         edge_hits = 0;
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         failures++;
      endtask

      function void set_limit(int index, logic [31:0] value);
         if (index == REG_X_LIMIT) begin
            x_limit = value[XW-1:0];
         end else begin
            y_limit = value[YW-1:0];
         end
      endfunction

      function int pending();
         return due_cursors.size();
      endfunction

      function int clamp_axis(int v, int limit);
         if (v < 0) begin
            return 0;
         end
         if (v > limit) begin
            return limit;
         end
         return v;
      endfunction

      // Advances the link by one received byte; a packet's last byte yields an update.
      function void note_byte(logic [7:0] rx);
         int         dx;
         int         dy;
         int         nx;
         int         ny;
         cursor_type c;
         case (phase)
            PHASE_ACK: begin
               // The acknowledge byte's value does not matter.
               phase = PHASE_STREAM;
               slot = SLOT_STATUS;
            end
            PHASE_STREAM: begin
               case (slot)
                  SLOT_STATUS: begin
                     status_byte = rx;
                     slot = SLOT_DX;
                  end
                  SLOT_DX: begin
                     dx_byte = rx;
                     slot = SLOT_DY;
                  end
                  default: begin
                     slot = SLOT_STATUS;
                     dx = int'(dx_byte);
                     if (status_byte[STATUS_X_SIGN_BIT]) begin
                        dx -= 256;
                     end
                     dy = int'(rx);
                     if (status_byte[STATUS_Y_SIGN_BIT]) begin
                        dy -= 256;
                     end
                     // X moves right with a positive delta, Y moves up.
                     nx = clamp_axis(int'(pos_x) + dx, int'(x_limit));
                     ny = clamp_axis(int'(pos_y) - dy, int'(y_limit));
                     pos_x = nx[XW-1:0];
                     pos_y = ny[YW-1:0];
                     if (nx == 0 || nx == int'(x_limit) || ny == 0 || ny == int'(y_limit)) begin
                        edge_hits++;
                     end
                     c.cursor_x = nx[XW-1:0];
                     c.cursor_y = ny[YW-1:0];
                     c.left_button = status_byte[STATUS_LEFT_BIT];
                     c.word_address = ADDR_W'((ny * LINE_WORDS + (nx / 16) * 2) % 65536);
                     c.byte_select = 1'((nx / 8) % 2);
                     c.bit_index = 3'(7 - nx % 8);
                     due_cursors.push_back(c);
                  end
               endcase
            end
            default: begin
               // The byte after reset is dropped; an unused phase behaves alike.
               phase = PHASE_ACK;
            end
         endcase
      endfunction

      // Compares one update from the block with the oldest one due.
      task check_cursor(cursor_type got);
         cursor_type want;
         if (due_cursors.size() == 0) begin
            report($sformatf("cursor update x=%0d y=%0d with none due",
                             got.cursor_x, got.cursor_y));
         end else begin
            want = due_cursors.pop_front();
            updates_checked++;
            if (got.cursor_x !== want.cursor_x) begin
               report($sformatf("cursor_x %0d, want %0d", got.cursor_x, want.cursor_x));
            end
            if (got.cursor_y !== want.cursor_y) begin
               report($sformatf("cursor_y %0d, want %0d", got.cursor_y, want.cursor_y));
            end
            if (got.left_button !== want.left_button) begin
               report($sformatf("left_button %b, want %b", got.left_button,
                                want.left_button));
            end
            if (got.word_address !== want.word_address) begin
               report($sformatf("word_address %0d, want %0d", got.word_address,
                                want.word_address));
            end
            if (got.byte_select !== want.byte_select) begin
               report($sformatf("byte_select %b, want %b", got.byte_select,
                                want.byte_select));
            end
            if (got.bit_index !== want.bit_index) begin
               report($sformatf("bit_index %0d, want %0d", got.bit_index, want.bit_index));
            end
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [XW-1:0]     rsp_cursor_x;
   logic [YW-1:0]     rsp_cursor_y;
   logic              rsp_left_button;
   logic [ADDR_W-1:0] rsp_word_address;
   logic              rsp_byte_select;
   logic [2:0]        rsp_bit_index;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   cursor_scoreboard sb = new();
   bit               quiet = 1'b0;
   int               hold_left = 0;
   int               bytes_sent = 0;
   int               limit_settings = 0;
   int               cycles = 0;

   ps2_mouse_cursor_tracker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_word_address (rsp_word_address),
      .rsp_byte_select  (rsp_byte_select),
      .rsp_bit_index    (rsp_bit_index),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one byte, with a random gap first, and returns once it is taken.
   task send_byte(logic [7:0] rx);
      while (!quiet && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_byte(rx);
      bytes_sent++;
   endtask

   // Mostly random bytes, with the delta extremes turning up often.
   function logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task run_bytes(int count);
      for (int i = 0; i < count; i++) begin
         send_byte(pick_byte());
      end
   endtask

   // Stops offering bytes until every update due has been taken.
   task pause_until_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.pending() > 0);
   endtask

   task csr_write(int index, logic [31:0] value);
      logic [31:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      sb.set_limit(index, value);
      // Read the register back.
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== value) begin
         sb.report($sformatf("register %0d reads %0d, written %0d", index, got, value));
      end
   endtask

   // Sets both limits once the block has gone quiet.
   task set_limits(logic [31:0] x_lim, logic [31:0] y_lim);
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_X_LIMIT, x_lim);
      csr_write(REG_Y_LIMIT, y_lim);
      limit_settings++;
   endtask

   // Result side: takes updates, stalls at random or for a long hold-off.
   initial begin
      cursor_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.cursor_x = rsp_cursor_x;
            got.cursor_y = rsp_cursor_y;
            got.left_button = rsp_left_button;
            got.word_address = rsp_word_address;
            got.byte_select = rsp_byte_select;
            got.bit_index = rsp_bit_index;
            sb.check_cursor(got);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 32);
         end
      end
   end

   // Cycle limit.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ERROR: cycle limit of %0d reached with %0d updates due",
               CYCLE_LIMIT, sb.pending());
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [7:0] directed[$];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Dropped byte, acknowledge, then packets over both signs, the delta
      // extremes, the left button, and clamping at zero on both axes and at the X limit.
      directed = '{8'hA5, 8'h3C,
                   8'h09, 8'h7F, 8'h00,
                   8'h38, 8'h80, 8'h80,
                   8'h08, 8'hFF, 8'hFF,
                   8'h18, 8'h00, 8'h00,
                   8'h29, 8'hFF, 8'h00,
                   8'h08, 8'hFF, 8'hFF,
                   8'h38, 8'h00, 8'h00,
                   8'h18, 8'h00, 8'hFF,
                   8'h18, 8'h00, 8'h7F};
      foreach (directed[i]) begin
         send_byte(directed[i]);
      end

      set_limits(32'd1023, 32'd511);
      run_bytes(120);
      // Long hold-off on the result side while bytes keep coming.
      hold_left = 80;
      run_bytes(130);

      // A zero limit pins the axis; the stored position is not re-clamped early.
      set_limits(32'd0, 32'd0);
      run_bytes(60);
      set_limits(32'd1, 32'd1);
      run_bytes(60);

      set_limits(32'($urandom_range(1023, 1)), 32'($urandom_range(511, 1)));
      run_bytes(125);
      pause_until_drained();
      run_bytes(125);

      set_limits(32'(X_LIMIT_RESET), 32'(Y_LIMIT_RESET));
      quiet = 1'b1;
      run_bytes(150);
      quiet = 1'b0;
      run_bytes(230);

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d mouse bytes and checked %0d cursor updates under %0d limit settings.",
               bytes_sent, sb.updates_checked, limit_settings);
      $display("The cursor reached a screen edge in %0d of those updates.", sb.edge_hits);
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
